// File: sv/sle_pkg.sv
// Shared types, character codes and echo-sequence helpers for the serial line editor.
// Depends on nothing; the controller, output stage, top level and testbench use it.
package sle_pkg;

	localparam int LINE_LEN_DEF = 10;

	localparam logic [7:0] CHR_BS   = 8'h08;
	localparam logic [7:0] CHR_LF   = 8'h0a;
	localparam logic [7:0] CHR_CR   = 8'h0d;
	localparam logic [7:0] CHR_SP   = 8'h20;
	localparam logic [7:0] CHR_DEL  = 8'h7f;
	localparam logic [7:0] CHR_ZERO = 8'h30;
	localparam logic [7:0] CHR_LOWZ = 8'h7a;
	localparam logic [7:0] CHR_E    = 8'h45;
	localparam logic [7:0] CHR_R    = 8'h52;
	localparam logic [7:0] CHR_O    = 8'h4f;

	typedef enum logic [1:0] {
		MODE_CHAR    = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_READ    = 2'd2
	} mode_t;

	// Kind of result run that one item produces.
	typedef enum logic [2:0] {
		SEQ_NONE    = 3'd0,
		SEQ_ECHO    = 3'd1,
		SEQ_RUBOUT  = 3'd2,
		SEQ_NEWLINE = 3'd3,
		SEQ_ERROR   = 3'd4
	} seq_t;

	typedef struct packed {
		seq_t        kind;
		logic [7:0]  ch;
		logic        taken;
		logic        line_ready;
		logic [3:0]  line_length;
		logic        ovf;
		logic        rd_ok;
	} desc_t;

	function automatic logic [3:0] seq_len(input seq_t kind);
		logic [3:0] n;
		unique case (kind)
			SEQ_RUBOUT:  n = 4'd3;
			SEQ_NEWLINE: n = 4'd2;
			SEQ_ERROR:   n = 4'd10;
			default:     n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] seq_char(input seq_t kind, input logic [3:0] cnt,
		input logic [7:0] ch);
		logic [7:0] c;
		c = 8'h00;
		unique case (kind)
			SEQ_ECHO: c = ch;
			SEQ_RUBOUT: c = (cnt == 4'd1) ? CHR_SP : CHR_BS;
			SEQ_NEWLINE: c = (cnt == 4'd0) ? CHR_CR : CHR_LF;
			SEQ_ERROR: begin
				// The stored character, then CR LF "ERROR" CR LF.
				case (cnt)
					4'd0:    c = ch;
					4'd1:    c = CHR_CR;
					4'd2:    c = CHR_LF;
					4'd3:    c = CHR_E;
					4'd4:    c = CHR_R;
					4'd5:    c = CHR_R;
					4'd6:    c = CHR_O;
					4'd7:    c = CHR_R;
					4'd8:    c = CHR_CR;
					default: c = CHR_LF;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: sv/sle_if.sv
// Valid/ready channel interfaces for command items and result items.
// Stand-alone; field widths follow the fixed item format of the line editor.
interface sle_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] rx_char;
	logic [3:0] read_index;

	modport source(output valid, output mode, output rx_char, output read_index, input ready);
	modport sink(input valid, input mode, input rx_char, input read_index, output ready);
endinterface

interface sle_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_valid;
	logic       last;
	logic       char_taken;
	logic       line_ready;
	logic [3:0] line_length;
	logic       overflow_error;
	logic [7:0] read_data;

	modport source(output valid, output out_char, output out_valid, output last,
		output char_taken, output line_ready, output line_length,
		output overflow_error, output read_data, input ready);
	modport sink(input valid, input out_char, input out_valid, input last,
		input char_taken, input line_ready, input line_length,
		input overflow_error, input read_data, output ready);
endinterface

// File: sv/sle_buffer.sv
// Line buffer memory: one write port and one read port with registered read data.
// Depends on nothing; depth and address width come from the top level.
module sle_buffer #(
	parameter int DEPTH = 11,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/sle_ctrl.sv
// Item decoder and line state: write position, pending flag and buffer write commands.
// Depends on sle_pkg for codes, the descriptor type and character constants.
module sle_ctrl #(
	parameter int LINE_LEN = sle_pkg::LINE_LEN_DEF,
	parameter int AW       = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [1:0]     mode,
	input  logic [7:0]     rx_char,
	input  logic [3:0]     read_index,
	output sle_pkg::desc_t desc,
	output logic           wr_en,
	output logic [AW-1:0]  wr_addr,
	output logic [7:0]     wr_data,
	output logic           rd_en,
	output logic [AW-1:0]  rd_addr
);

	logic [AW-1:0] wp_q;
	logic          pending_q;
	logic          clr_q;

	logic [AW-1:0] wp_d;
	logic          pending_d;
	logic          clr_d;
	logic          item_wr;
	logic [7:0]    item_data;
	logic [7:0]    c;
	logic          idx_ok;

	assign idx_ok = (32'(read_index) <= 32'(LINE_LEN));

	always_comb begin
		c = (rx_char == sle_pkg::CHR_LF) ? sle_pkg::CHR_CR : rx_char;
		wp_d      = wp_q;
		pending_d = pending_q;
		clr_d     = 1'b0;
		item_wr   = 1'b0;
		item_data = 8'h00;
		desc.kind  = sle_pkg::SEQ_NONE;
		desc.ch    = c;
		desc.taken = 1'b1;
		desc.ovf   = 1'b0;
		desc.rd_ok = 1'b0;
		unique case (sle_pkg::mode_t'(mode))
			sle_pkg::MODE_RELEASE: begin
				wp_d      = '0;
				pending_d = 1'b0;
			end
			sle_pkg::MODE_READ: begin
				desc.rd_ok = idx_ok;
			end
			sle_pkg::MODE_CHAR: begin
				if (pending_q) begin
					desc.taken = 1'b0;
				end else if (c == sle_pkg::CHR_CR) begin
					item_wr   = 1'b1;
					desc.kind = sle_pkg::SEQ_NEWLINE;
					pending_d = 1'b1;
				end else if (c == sle_pkg::CHR_BS || c == sle_pkg::CHR_DEL) begin
					if (wp_q != '0) begin
						wp_d      = wp_q - AW'(1);
						desc.kind = (c == sle_pkg::CHR_BS) ? sle_pkg::SEQ_RUBOUT
							: sle_pkg::SEQ_ECHO;
					end
				end else if (c >= sle_pkg::CHR_ZERO && c <= sle_pkg::CHR_LOWZ) begin
					item_wr   = 1'b1;
					item_data = c;
					desc.kind = sle_pkg::SEQ_ECHO;
					if (wp_q == AW'(LINE_LEN)) begin
						// Overflow: the line is emptied and entry zero is cleared next cycle.
						desc.kind = sle_pkg::SEQ_ERROR;
						desc.ovf  = 1'b1;
						wp_d      = '0;
						pending_d = 1'b1;
						clr_d     = 1'b1;
					end else begin
						wp_d = wp_q + AW'(1);
					end
				end
			end
			default: begin
			end
		endcase
		desc.line_ready  = pending_d;
		desc.line_length = 4'(wp_d);
	end

	// An overflow item emits ten results, so no item can arrive while entry zero is cleared.
	always_comb begin
		if (clr_q) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = 8'h00;
		end else begin
			wr_en   = accept && item_wr;
			wr_addr = wp_q;
			wr_data = item_data;
		end
	end

	assign rd_en   = accept && desc.rd_ok;
	assign rd_addr = AW'(read_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			pending_q <= 1'b0;
			clr_q     <= 1'b0;
		end else begin
			clr_q <= accept && clr_d;
			if (accept) begin
				wp_q      <= wp_d;
				pending_q <= pending_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_clr_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !accept)
		else $error("item accepted while entry zero is being cleared");
	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wp_q) <= 32'(LINE_LEN))
		else $error("write position beyond line length");
	a_refused_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pending_q && mode == sle_pkg::MODE_CHAR) |=> $stable(wp_q) && pending_q)
		else $error("refused character changed the line state");
	a_ovf_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && clr_d) |=> (wp_q == '0) && pending_q && clr_q)
		else $error("overflow did not empty the line");
`endif

endmodule

// File: sv/sle_emit.sv
// Output stage: holds one item descriptor and steps through its result run.
// Depends on sle_pkg for the descriptor type and echo-sequence helpers.
module sle_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  sle_pkg::desc_t       desc,
	input  logic [7:0]           rd_data,
	output logic                 take,
	sle_rsp_if.source            rsp
);

	logic           valid_s1;
	sle_pkg::desc_t desc_s1;
	logic [3:0]     cnt_s1;
	logic           at_last;
	logic           done;

	assign at_last = (cnt_s1 == sle_pkg::seq_len(desc_s1.kind) - 4'd1);
	assign done    = valid_s1 && rsp.ready && at_last;
	assign take    = !valid_s1 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s1   <= 4'd0;
		end else if (take) begin
			valid_s1 <= accept;
			cnt_s1   <= 4'd0;
		end else if (rsp.ready) begin
			cnt_s1 <= cnt_s1 + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && accept) begin
			desc_s1 <= desc;
		end
	end

	assign rsp.valid          = valid_s1;
	assign rsp.out_valid      = (desc_s1.kind != sle_pkg::SEQ_NONE);
	assign rsp.out_char       = sle_pkg::seq_char(desc_s1.kind, cnt_s1, desc_s1.ch);
	assign rsp.last           = at_last;
	assign rsp.char_taken     = desc_s1.taken;
	assign rsp.line_ready     = desc_s1.line_ready;
	assign rsp.line_length    = desc_s1.line_length;
	assign rsp.overflow_error = desc_s1.ovf;
	// Read data arrives from the buffer in the cycle after the item is accepted.
	assign rsp.read_data      = desc_s1.rd_ok ? rd_data : 8'h00;

`ifndef SYNTHESIS
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.out_valid) |-> rsp.last)
		else $error("status-only item produced more than one result");
	a_ovf_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.overflow_error) |-> rsp.line_ready && rsp.line_length == 4'd0)
		else $error("overflow result without an emptied ready line");
	a_run_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && !rsp.last) |=> rsp.valid && cnt_s1 == $past(cnt_s1) + 4'd1)
		else $error("result run did not advance");
`endif

endmodule

// File: sv/serial_line_editor_unit.sv
// Serial line editor top level. An item's first result appears in the cycle after acceptance.
// An item giving one result is taken every cycle while the result side is ready; an item with
// an echo run of n characters (2, 3 or 10) holds the output stage until its last result is taken.
// Reset clears the write position and the pending flag at once; the line buffer is not
// cleared and its entries are undefined until written.
// Depends on sle_pkg, sle_if, sle_buffer, sle_ctrl and sle_emit.
module serial_line_editor_unit #(
	parameter int LINE_LEN = sle_pkg::LINE_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sle_cmd_if.sink    cmd,
	sle_rsp_if.source  rsp
);

	localparam int DEPTH = LINE_LEN + 1;
	localparam int AW    = $clog2(DEPTH);

	sle_pkg::desc_t desc;
	logic           accept;
	logic           take;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [7:0]     wr_data;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic [7:0]     rd_data;

	assign cmd.ready = take;
	assign accept    = cmd.valid && take;

	sle_ctrl #(
		.LINE_LEN(LINE_LEN),
		.AW      (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.mode      (cmd.mode),
		.rx_char   (cmd.rx_char),
		.read_index(cmd.read_index),
		.desc      (desc),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr)
	);

	sle_buffer #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_buffer (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	sle_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.desc   (desc),
		.rd_data(rd_data),
		.take   (take),
		.rsp    (rsp)
	);

endmodule

// File: dv/tb_serial_line_editor_unit.sv
// Self-checking testbench for serial_line_editor_unit: a directed table, then random edit sessions.
// Every result item is compared against an in-bench model of the line editor.
// Depends on sle_pkg, sle_if and the serial_line_editor_unit RTL.
module tb_serial_line_editor_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_LEN = sle_pkg::LINE_LEN_DEF;
	localparam logic [1:0] MODE_VOID = 2'd3;
	localparam logic [71:0] ERR_TEXT = {sle_pkg::CHR_CR, sle_pkg::CHR_LF, sle_pkg::CHR_E,
		sle_pkg::CHR_R, sle_pkg::CHR_R, sle_pkg::CHR_O, sle_pkg::CHR_R,
		sle_pkg::CHR_CR, sle_pkg::CHR_LF};
	localparam int RAND_ITEMS = 84;
	localparam int QUIET_ITEMS = 20;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_valid;
		logic       last;
		logic       char_taken;
		logic       line_ready;
		logic [3:0] line_length;
		logic       overflow_error;
		logic [7:0] read_data;
	} line_result_t;

	typedef struct {
		logic [1:0]   mode;
		logic [7:0]   rx_char;
		logic [3:0]   read_index;
		bit           typed;
		line_result_t res;
	} script_row_t;

	logic clk;
	logic arst_n;

	sle_cmd_if cmd_ch();
	sle_rsp_if rsp_ch();

	serial_line_editor_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Model state of the editor.
	logic [7:0] line_buf_model [0:LINE_LEN] = '{default: 8'h00};
	bit         written_model [0:LINE_LEN] = '{default: 1'b0};
	logic [3:0] wr_pos_model = '0;
	logic       pending_model = 1'b0;

	line_result_t console_q [$];
	script_row_t  script_q [$];

	// Typed expectation that travels with the item on the command channel.
	bit           drv_typed;
	line_result_t drv_expect;

	bit quiet_tail;
	int mismatches = 0;
	int cycles = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic line_result_t status_only(input logic taken, input logic ready,
		input logic [3:0] len, input logic [7:0] rdata);
		line_result_t r;
		r = '0;
		r.last = 1'b1;
		r.char_taken = taken;
		r.line_ready = ready;
		r.line_length = len;
		r.read_data = rdata;
		return r;
	endfunction

	function automatic logic [3:0] pick_read_index();
		logic [3:0] idx;
		idx = 4'($urandom_range(0, 15));
		if (idx <= LINE_LEN && !written_model[idx])
			idx = 4'($urandom_range(LINE_LEN + 1, 15));
		return idx;
	endfunction

	// Applies one accepted item to the model and queues the result items it causes.
	task automatic edit_line(input logic [1:0] mode, input logic [7:0] rx, input logic [3:0] idx);
		logic [7:0]   run [0:9];
		int           n;
		logic         taken;
		logic         ovf;
		logic [7:0]   rdata;
		logic [7:0]   c;
		line_result_t r;
		n = 0;
		taken = 1'b1;
		ovf = 1'b0;
		rdata = 8'h00;
		c = rx;
		case (mode)
			sle_pkg::MODE_RELEASE: begin
				wr_pos_model = '0;
				pending_model = 1'b0;
			end
			sle_pkg::MODE_READ: begin
				rdata = (idx <= LINE_LEN) ? line_buf_model[idx] : 8'h00;
			end
			sle_pkg::MODE_CHAR: begin
				if (pending_model) begin
					taken = 1'b0;
				end else begin
					if (c == sle_pkg::CHR_LF)
						c = sle_pkg::CHR_CR;
					if (c == sle_pkg::CHR_CR) begin
						line_buf_model[wr_pos_model] = 8'h00;
						written_model[wr_pos_model] = 1'b1;
						run[0] = sle_pkg::CHR_CR;
						run[1] = sle_pkg::CHR_LF;
						n = 2;
						pending_model = 1'b1;
					end else if (c == sle_pkg::CHR_BS) begin
						if (wr_pos_model != 0) begin
							wr_pos_model--;
							run[0] = sle_pkg::CHR_BS;
							run[1] = sle_pkg::CHR_SP;
							run[2] = sle_pkg::CHR_BS;
							n = 3;
						end
					end else if (c == sle_pkg::CHR_DEL) begin
						if (wr_pos_model != 0) begin
							wr_pos_model--;
							run[0] = sle_pkg::CHR_DEL;
							n = 1;
						end
					end else if (c >= sle_pkg::CHR_ZERO && c <= sle_pkg::CHR_LOWZ) begin
						run[0] = c;
						n = 1;
						line_buf_model[wr_pos_model] = c;
						written_model[wr_pos_model] = 1'b1;
						wr_pos_model++;
						if (wr_pos_model > LINE_LEN) begin
							// Overflow: the stored character is followed by the error banner.
							for (int k = 0; k < 9; k++)
								run[1 + k] = ERR_TEXT[71 - 8 * k -: 8];
							n = 10;
							wr_pos_model = '0;
							line_buf_model[0] = 8'h00;
							written_model[0] = 1'b1;
							pending_model = 1'b1;
							ovf = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		if (n == 0) begin
			r = status_only(taken, pending_model, wr_pos_model, rdata);
			r.overflow_error = ovf;
			console_q.push_back(r);
		end else begin
			for (int k = 0; k < n; k++) begin
				r.out_char = run[k];
				r.out_valid = 1'b1;
				r.last = (k == n - 1);
				r.char_taken = taken;
				r.line_ready = pending_model;
				r.line_length = wr_pos_model;
				r.overflow_error = ovf;
				r.read_data = rdata;
				console_q.push_back(r);
			end
		end
	endtask

	task automatic note_diff(input string field, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
		end
	endtask

	task automatic check_result(input line_result_t e, input line_result_t a);
		note_diff("out_char", e.out_char, a.out_char);
		note_diff("out_valid", 8'(e.out_valid), 8'(a.out_valid));
		note_diff("last", 8'(e.last), 8'(a.last));
		note_diff("char_taken", 8'(e.char_taken), 8'(a.char_taken));
		note_diff("line_ready", 8'(e.line_ready), 8'(a.line_ready));
		note_diff("line_length", 8'(e.line_length), 8'(a.line_length));
		note_diff("overflow_error", 8'(e.overflow_error), 8'(a.overflow_error));
		note_diff("read_data", e.read_data, a.read_data);
	endtask

	// Predict on the command handshake first, so a result in the same edge finds its entry.
	always @(posedge clk) begin
		line_result_t seen;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				edit_line(cmd_ch.mode, cmd_ch.rx_char, cmd_ch.read_index);
				if (drv_typed) begin
					console_q.delete(console_q.size() - 1);
					console_q.push_back(drv_expect);
				end
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.out_char = rsp_ch.out_char;
				seen.out_valid = rsp_ch.out_valid;
				seen.last = rsp_ch.last;
				seen.char_taken = rsp_ch.char_taken;
				seen.line_ready = rsp_ch.line_ready;
				seen.line_length = rsp_ch.line_length;
				seen.overflow_error = rsp_ch.overflow_error;
				seen.read_data = rsp_ch.read_data;
				if (console_q.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected result, expected none actual %0h",
						$time, seen);
				end else begin
					check_result(console_q.pop_front(), seen);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: bursts of ready with stalls between them, none in the quiet tail.
	initial begin : rsp_ready_gen
		int run_len;
		int stall_len;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
			repeat (run_len) begin
				@(negedge clk);
				rsp_ch.ready = 1'b1;
			end
			if (!quiet_tail) begin
				stall_len = $urandom_range(1, 19);
				repeat (stall_len) begin
					@(negedge clk);
					rsp_ch.ready = 1'b0;
				end
			end
		end
	end

	task automatic add_row(input logic [1:0] mode, input logic [7:0] ch, input logic [3:0] idx);
		script_row_t row;
		row.mode = mode;
		row.rx_char = ch;
		row.read_index = idx;
		row.typed = 1'b0;
		row.res = '0;
		script_q.push_back(row);
	endtask

	task automatic add_typed(input logic [1:0] mode, input logic [7:0] ch, input logic [3:0] idx,
		input line_result_t res);
		script_row_t row;
		row.mode = mode;
		row.rx_char = ch;
		row.read_index = idx;
		row.typed = 1'b1;
		row.res = res;
		script_q.push_back(row);
	endtask

	// Drives one item at the current falling edge and holds it until accepted.
	task automatic put_item(input logic [1:0] mode, input logic [7:0] ch, input logic [3:0] idx,
		input bit typed, input line_result_t res);
		cmd_ch.valid = 1'b1;
		cmd_ch.mode = mode;
		cmd_ch.rx_char = ch;
		cmd_ch.read_index = idx;
		drv_typed = typed;
		drv_expect = res;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	task automatic sender_gap();
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			repeat (gap) begin
				@(negedge clk);
				cmd_ch.valid = 1'b0;
			end
		end
	endtask

	initial begin : stimulus
		logic [1:0] mode;
		logic [7:0] ch;
		logic [3:0] idx;
		logic [3:0] line_goal;
		int         pick;
		string      fill;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = sle_pkg::MODE_CHAR;
		cmd_ch.rx_char = 8'h00;
		cmd_ch.read_index = 4'd0;
		drv_typed = 1'b0;
		drv_expect = '0;
		quiet_tail = 1'b0;
		arst_n = 1'b0;

		add_typed(sle_pkg::MODE_RELEASE, 8'h00, 4'd0, status_only(1'b1, 1'b0, 4'd0, 8'h00));
		add_typed(MODE_VOID, 8'hff, 4'd15, status_only(1'b1, 1'b0, 4'd0, 8'h00));
		add_typed(sle_pkg::MODE_READ, 8'h00, 4'd15, status_only(1'b1, 1'b0, 4'd0, 8'h00));
		add_typed(sle_pkg::MODE_CHAR, sle_pkg::CHR_BS, 4'd0,
			status_only(1'b1, 1'b0, 4'd0, 8'h00));
		add_typed(sle_pkg::MODE_CHAR, sle_pkg::CHR_DEL, 4'd0,
			status_only(1'b1, 1'b0, 4'd0, 8'h00));
		add_typed(sle_pkg::MODE_CHAR, 8'h00, 4'd0, status_only(1'b1, 1'b0, 4'd0, 8'h00));
		add_typed(sle_pkg::MODE_CHAR, 8'hff, 4'd0, status_only(1'b1, 1'b0, 4'd0, 8'h00));
		add_row(sle_pkg::MODE_CHAR, sle_pkg::CHR_ZERO, 4'd0);
		add_row(sle_pkg::MODE_CHAR, sle_pkg::CHR_DEL, 4'd0);
		add_row(sle_pkg::MODE_CHAR, sle_pkg::CHR_LOWZ, 4'd0);
		add_row(sle_pkg::MODE_CHAR, "q", 4'd0);
		add_row(sle_pkg::MODE_CHAR, sle_pkg::CHR_BS, 4'd0);
		add_row(sle_pkg::MODE_CHAR, sle_pkg::CHR_LF, 4'd0);
		// A pending line refuses further characters.
		add_typed(sle_pkg::MODE_CHAR, "A", 4'd0, status_only(1'b0, 1'b1, 4'd1, 8'h00));
		add_row(sle_pkg::MODE_READ, 8'h00, 4'd0);
		add_typed(sle_pkg::MODE_RELEASE, 8'h00, 4'd0, status_only(1'b1, 1'b0, 4'd0, 8'h00));
		// Eleven characters overflow a ten-character line.
		fill = "123456789aZ";
		for (int k = 0; k < fill.len(); k++)
			add_row(sle_pkg::MODE_CHAR, fill[k], 4'd0);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (script_q[k]) begin
			sender_gap();
			@(negedge clk);
			put_item(script_q[k].mode, script_q[k].rx_char, script_q[k].read_index,
				script_q[k].typed, script_q[k].res);
		end

		line_goal = 4'd4;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == RAND_ITEMS / 2) begin
				@(negedge clk);
				cmd_ch.valid = 1'b0;
				while (console_q.size() != 0)
					@(negedge clk);
			end
			quiet_tail = (i >= RAND_ITEMS - QUIET_ITEMS);
			sender_gap();
			@(negedge clk);
			ch = 8'($urandom_range(0, 255));
			idx = 4'($urandom_range(0, 15));
			if (pending_model) begin
				pick = $urandom_range(0, 9);
				if (pick < 5)
					mode = sle_pkg::MODE_RELEASE;
				else if (pick < 9)
					mode = sle_pkg::MODE_READ;
				else
					mode = sle_pkg::MODE_CHAR;
			end else if (wr_pos_model < line_goal) begin
				pick = $urandom_range(0, 19);
				mode = sle_pkg::MODE_CHAR;
				if (pick <= 12)
					ch = 8'($urandom_range(sle_pkg::CHR_ZERO, sle_pkg::CHR_LOWZ));
				else if (pick == 13)
					ch = sle_pkg::CHR_BS;
				else if (pick == 14)
					ch = sle_pkg::CHR_DEL;
				else if (pick == 15)
					mode = sle_pkg::MODE_READ;
				else if (pick == 17)
					mode = MODE_VOID;
				else if (pick == 18)
					mode = sle_pkg::MODE_RELEASE;
				else if (pick == 19)
					ch = $urandom_range(0, 1) ? sle_pkg::CHR_CR : sle_pkg::CHR_LF;
			end else begin
				mode = sle_pkg::MODE_CHAR;
				ch = $urandom_range(0, 1) ? sle_pkg::CHR_CR : sle_pkg::CHR_LF;
			end
			if (mode == sle_pkg::MODE_READ)
				idx = pick_read_index();
			// A goal past the line length drives the next line into overflow.
			if (mode == sle_pkg::MODE_RELEASE)
				line_goal = ($urandom_range(0, 3) == 0) ? 4'(LINE_LEN + 1)
					: 4'($urandom_range(0, LINE_LEN));
			put_item(mode, ch, idx, 1'b0, '0);
		end
		@(negedge clk);
		cmd_ch.valid = 1'b0;

		while (console_q.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
sv/sle_pkg.sv
sv/sle_if.sv
sv/sle_buffer.sv
sv/sle_ctrl.sv
sv/sle_emit.sv
sv/serial_line_editor_unit.sv
dv/tb_serial_line_editor_unit.sv
